[design/spd_pkg.sv]
`default_nettype none

package spd_pkg;

  // Storage sizes
  localparam int DELAY_LEN    = 256;
  localparam int SINE_ENTRIES = 256;
  localparam int PTR_W        = $clog2(DELAY_LEN);
  localparam int SIN_IDX_W    = $clog2(SINE_ENTRIES + 1);

  // Sample and coefficient formats
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;

  // Fixed coefficients: 0.35 and 0.55 in Q0.16, pi/2 in Q30
  localparam int MID_K  = 22938;
  localparam int SIDE_K = 36045;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Shared multiplier: signed A times unsigned B
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

  typedef logic signed [MUL_A_W-1:0]  mul_a_t;
  typedef logic        [MUL_B_W-1:0]  mul_b_t;
  typedef logic signed [MUL_P_W-1:0]  mul_p_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_APPLY_GAIN = CFG_IDX_W'(1);

  // Delay ring control from the sequencer
  typedef struct packed {
    logic rd;
    logic push;
  } ring_ctl_t;

  // Quarter-wave sine table, unsigned Q1.15
  typedef logic [SAMPLE_W-1:0] sine_tab_t [0:SINE_ENTRIES];

  // Build the table with a truncating Q30 Taylor series up to x^15
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned mag;
    longint          sum;
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      x = (64'(i) * HALF_PI_Q30 + 64'(SINE_ENTRIES / 2)) / 64'(SINE_ENTRIES);
      mag = x;
      sum = $signed(x);
      for (int k = 1; k <= 7; k++) begin
        mag = (mag * x) >> 30;
        mag = (mag * x) >> 30;
        mag = mag / 64'((2 * k) * (2 * k + 1));
        if (k[0]) begin
          sum = sum - $signed(mag);
        end else begin
          sum = sum + $signed(mag);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > (64'sd1 <<< 30)) begin
        sum = 64'sd1 <<< 30;
      end
      tab[i] = SAMPLE_W'((sum + 64'sd16384) >>> 15);
    end
    return tab;
  endfunction

  // Clamp a wide signed value to Q1.15
  function automatic sample_t sat16(input mul_p_t v);
    sample_t r;
    if (v > MUL_P_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -MUL_P_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/spd_mul.sv]
`default_nettype none

module spd_mul (
  input  wire logic            clk_i,
  input  wire spd_pkg::mul_a_t a_i,
  input  wire spd_pkg::mul_b_t b_i,
  output spd_pkg::mul_p_t      prod_o
);
  import spd_pkg::*;

  mul_p_t prod_q;

  // Multiply signed A by unsigned B, register the full product
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * $signed({1'b0, b_i});
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

[design/spd_sine_rom.sv]
`default_nettype none

module spd_sine_rom (
  input  wire logic                         clk_i,
  input  wire logic [spd_pkg::SIN_IDX_W-1:0] addr_i,
  output logic      [spd_pkg::SAMPLE_W-1:0]  data_o
);
  import spd_pkg::*;

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  logic [SAMPLE_W-1:0] data_q;

  // Registered table lookup
  always_ff @(posedge clk_i) begin
    data_q <= SINE_TAB[addr_i];
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[design/spd_delay_ring.sv]
`default_nettype none

module spd_delay_ring (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire spd_pkg::ring_ctl_t ctl_i,
  input  wire spd_pkg::sample_t   wr_data_i,
  output spd_pkg::sample_t        rd_data_o
);
  import spd_pkg::*;

  sample_t          mem [DELAY_LEN];
  logic [PTR_W-1:0] ptr_q;
  logic             wrapped_q;
  sample_t          rd_data_q;
  logic             rd_ok_q;

  // Read the oldest entry and write the new one at the same pointer
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      rd_data_q <= mem[ptr_q];
    end
    if (ctl_i.push) begin
      mem[ptr_q] <= wr_data_i;
    end
  end

  // Advance the pointer; until the first wrap every read slot is still empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q     <= '0;
      wrapped_q <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      if (ctl_i.rd) begin
        rd_ok_q <= wrapped_q;
      end
      if (ctl_i.push) begin
        if (ptr_q == PTR_W'(DELAY_LEN - 1)) begin
          ptr_q     <= '0;
          wrapped_q <= 1'b1;
        end else begin
          ptr_q <= ptr_q + PTR_W'(1);
        end
      end
    end
  end

  assign rd_data_o = rd_ok_q ? rd_data_q : '0;

endmodule

`default_nettype wire

[design/stereo_spread_delay_panner_core.sv]
`default_nettype none

// Stereo spread delay panner. Each input transfer carries one mono sample,
// its gain, a pan position and the left/right samples to mix onto; each one
// yields exactly one left/right output transfer. The sample (optionally
// gained) enters a 256-entry delay line; the mid term is panned with
// constant-power cosine/sine from a quarter-wave table and the delayed
// sample, scaled by spread, is added left and subtracted right, both
// saturated to Q1.15. One shared 34x17-bit multiplier carries the seven
// products of an item one after another, the last product is then landed in
// the output register, and the block goes back to idle. The input stalls
// while an item is in work; a finished result waits in the output register
// and, if still untaken, holds the next item at its final step.
// Configuration: index 0 is spread (Q0.16, reset 0), index 1 is apply_gain
// (reset 1); other indexes are ignored. The delay line reads as zero until
// written, no clearing pass is needed after reset.
module stereo_spread_delay_panner_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [spd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [spd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [15:0]            mono_sample_i,
  input  wire logic        [15:0]            gain_i,
  input  wire logic        [15:0]            pan_i,
  input  wire logic signed [15:0]            left_in_i,
  input  wire logic signed [15:0]            right_in_i,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [15:0]                 left_out_o,
  output logic signed [15:0]                 right_out_o
);
  import spd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAIN,
    S_MIDK,
    S_SIDE1,
    S_MID,
    S_SIDE2,
    S_COS,
    S_SIN,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [COEF_W-1:0] spread_q;
  logic              apply_gain_q;

  // Item registers
  sample_t              mono_q;
  logic [COEF_W-1:0]    gain_q;
  logic [SIN_IDX_W-1:0] sin_idx_q;
  sample_t              lin_q;
  sample_t              rin_q;

  // Intermediate results
  sample_t                 sample_q;
  logic [MUL_B_W-1:0]      midc_q;
  logic signed [31:0]      ds_q;
  logic signed [32:0]      mid_q;
  logic signed [47:0]      side_q;
  mul_p_t                  lacc_q;
  logic                    out_valid_q;
  sample_t                 left_out_q;
  sample_t                 right_out_q;

  // Datapath wiring
  mul_a_t               mul_a;
  mul_b_t               mul_b;
  mul_p_t               prod;
  logic [SIN_IDX_W-1:0] rom_addr;
  logic [SAMPLE_W-1:0]  rom_data;
  ring_ctl_t            ring_ctl;
  sample_t              delayed;
  sample_t              sample_d;
  mul_p_t               gain_rnd;
  mul_p_t               midk_rnd;
  mul_p_t               lsum;
  mul_p_t               rsum;
  mul_p_t               lrnd;
  mul_p_t               rrnd;
  logic [31:0]          idx_full;
  logic [SIN_IDX_W-1:0] idx_in;
  logic                 in_take;
  logic                 out_free;

  assign in_take  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Pan index, rounded and clamped to the table end
  assign idx_full = (32'(pan_i) * 32'(SINE_ENTRIES) + 32'd32768) >> 16;
  assign idx_in   = (idx_full > 32'(SINE_ENTRIES)) ? SIN_IDX_W'(SINE_ENTRIES)
                                                   : idx_full[SIN_IDX_W-1:0];

  // Gained sample, rounded half up and saturated, or the plain sample when gain is off
  assign gain_rnd = (prod + (MUL_P_W'(1) <<< 13)) >>> 14;
  assign sample_d = apply_gain_q ? sat16(gain_rnd) : mono_q;

  // Mid coefficient rounding
  assign midk_rnd = (prod + (MUL_P_W'(1) <<< 15)) >>> 16;

  // Channel sums in Q47 and their rounded values
  assign lsum = (MUL_P_W'(lin_q) <<< 32) + (prod <<< 1) + MUL_P_W'(side_q);
  assign rsum = (MUL_P_W'(rin_q) <<< 32) + (prod <<< 1) - MUL_P_W'(side_q);
  assign lrnd = (lacc_q + (MUL_P_W'(1) <<< 31)) >>> 32;
  assign rrnd = (rsum + (MUL_P_W'(1) <<< 31)) >>> 32;

  // Select multiplier operands per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_IDLE: begin
        mul_a = '0;
        mul_b = '0;
      end
      S_GAIN: begin
        mul_a = MUL_A_W'(mono_q);
        mul_b = MUL_B_W'(gain_q);
      end
      S_MIDK: begin
        mul_a = MUL_A_W'(MID_K);
        mul_b = MUL_B_W'(spread_q);
      end
      S_SIDE1: begin
        mul_a = MUL_A_W'(delayed);
        mul_b = MUL_B_W'(spread_q);
      end
      S_MID: begin
        mul_a = MUL_A_W'(sample_q);
        mul_b = midc_q;
      end
      S_SIDE2: begin
        mul_a = MUL_A_W'(ds_q);
        mul_b = MUL_B_W'(SIDE_K);
      end
      S_COS, S_SIN, S_FIN: begin
        mul_a = MUL_A_W'(mid_q);
        mul_b = MUL_B_W'(rom_data);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Cosine index while the mid product forms, sine index afterwards
  assign rom_addr = (state_q == S_SIDE2) ? SIN_IDX_W'(SINE_ENTRIES) - sin_idx_q
                                         : sin_idx_q;

  assign ring_ctl.rd   = (state_q == S_GAIN);
  assign ring_ctl.push = (state_q == S_MIDK);

  // Step through the products of one item
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_GAIN;
      S_GAIN:  state_d = S_MIDK;
      S_MIDK:  state_d = S_SIDE1;
      S_SIDE1: state_d = S_MID;
      S_MID:   state_d = S_SIDE2;
      S_SIDE2: state_d = S_COS;
      S_COS:   state_d = S_SIN;
      S_SIN:   state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state, configuration and the output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      spread_q     <= '0;
      apply_gain_q <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SPREAD:     spread_q     <= cfg_data_i[COEF_W-1:0];
          REG_APPLY_GAIN: apply_gain_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture item fields and each product as it leaves the multiplier
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mono_q    <= mono_sample_i;
      gain_q    <= gain_i;
      sin_idx_q <= idx_in;
      lin_q     <= left_in_i;
      rin_q     <= right_in_i;
    end
    case (state_q)
      S_MIDK:  sample_q <= sample_d;
      S_SIDE1: midc_q   <= MUL_B_W'(65536) - midk_rnd[MUL_B_W-1:0];
      S_MID:   ds_q     <= prod[31:0];
      S_SIDE2: mid_q    <= prod[32:0];
      S_COS:   side_q   <= prod[47:0];
      S_SIN:   lacc_q   <= lsum;
      S_FIN: begin
        if (out_free) begin
          left_out_q  <= sat16(lrnd);
          right_out_q <= sat16(rrnd);
        end
      end
      default: ;
    endcase
  end

  spd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  spd_sine_rom u_sine_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  spd_delay_ring u_delay_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ring_ctl),
    .wr_data_i (sample_d),
    .rd_data_o (delayed)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

endmodule

`default_nettype wire
